[design/gted_pkg.sv]
// Shared types, register indexes and the escape string for the guard-time escape detector.
// No dependencies; used by every module of the block.
`default_nettype none

package gted_pkg;

	// per-channel detector state, coded as reported on channel_state
	typedef enum logic [2:0] {
		DET_IDLE      = 3'd0,
		DET_ARMED     = 3'd1,
		DET_MATCHING  = 3'd2,
		DET_MATCHED   = 3'd3,
		DET_TRIGGERED = 3'd4
	} det_state_t;

	// sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_DONE
	} seq_state_t;

	// stored context of one channel
	typedef struct packed {
		det_state_t  st;
		logic [7:0]  cnt;
		logic [4:0]  mi;
	} chan_rec_t;

	// input word kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_ENABLE_MASK = 1'b0;
	localparam logic REG_GUARD_TICKS = 1'b1;

	localparam logic [7:0] GUARD_RESET = 8'd10;

	// escape string; positions past its end hold zero
	function automatic logic [7:0] pattern_char(input logic [4:0] pos);
		logic [7:0] ch;
		unique case (pos)
			5'd0:    ch = "+";
			5'd1:    ch = " ";
			5'd2:    ch = "r";
			5'd3:    ch = "e";
			5'd4:    ch = "s";
			5'd5:    ch = "t";
			5'd6:    ch = "a";
			5'd7:    ch = "r";
			5'd8:    ch = "t";
			5'd9:    ch = " ";
			5'd10:   ch = "a";
			5'd11:   ch = "s";
			5'd12:   ch = " ";
			5'd13:   ch = "m";
			5'd14:   ch = "o";
			5'd15:   ch = "d";
			5'd16:   ch = "e";
			5'd17:   ch = "m";
			5'd18:   ch = " ";
			5'd19:   ch = "+";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[design/guard_time_escape_detector.sv]
// Guard-time escape detector: sequencer, per-channel context store, config and result register.
// Depends on gted_pkg and gted_chan_unit.
`default_nettype none

// A word is either a received byte for one channel or a guard tick for all channels. One
// channel update unit serves every channel, one channel per cycle: a byte updates only its
// own channel, while a tick walks all channels in turn through that unit. item_stall is high
// from the accepting edge until the result moves into the output register, and that move
// waits while the previous result is still untaken. Configuration is always ready.
module guard_time_escape_detector import gted_pkg::*; #(
	parameter int CHANNELS       = 4,
	parameter int PATTERN_LENGTH = 20
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       item_valid,
	output logic       item_stall,
	input  logic       mode,
	input  logic [1:0] channel,
	input  logic [7:0] data_byte,

	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] channel_state,
	output logic [3:0] trigger_mask,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW    = (IDX_W > 2) ? IDX_W : 2;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(CHANNELS - 1);

	seq_state_t       seq_q, seq_d;
	logic             item_take;
	logic             out_free;
	logic             run_step;
	logic             load_result;

	logic [3:0]       enable_mask_q;
	logic [7:0]       guard_q;

	logic             tick_q;
	logic             chan_ok_q;
	logic [IDX_W-1:0] chan_idx_q;
	logic [7:0]       byte_q;
	logic [IDX_W-1:0] idx_q;
	det_state_t       cstate_q;

	chan_rec_t        rec_q [CHANNELS];
	chan_rec_t        cur, nxt;
	logic [CHANNELS-1:0] en_vec;
	logic [3:0]       mask_d;

	logic [CW-1:0]    chan_ext;
	logic             chan_ok;

	logic             result_valid_q;
	logic [2:0]       channel_state_q;
	logic [3:0]       trigger_mask_q;

	assign cfg_ready = 1'b1;
	assign chan_ext  = CW'(channel);
	assign chan_ok   = (int'(channel) < CHANNELS);
	assign item_take = item_valid && !item_stall;
	assign out_free  = !result_valid_q || !result_stall;

	// enable bits exist for the first four channels only
	for (genvar c = 0; c < CHANNELS; c++) begin : g_en
		if (c < 4) begin : g_on
			assign en_vec[c] = enable_mask_q[c];
		end else begin : g_off
			assign en_vec[c] = 1'b0;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_mask
		if (c < CHANNELS) begin : g_on
			assign mask_d[c] = en_vec[c] && (rec_q[c].st == DET_TRIGGERED);
		end else begin : g_off
			assign mask_d[c] = 1'b0;
		end
	end

	// next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_IDLE: begin
				if (item_take) seq_d = SEQ_RUN;
			end
			SEQ_RUN: begin
				if (!tick_q || idx_q == LAST) seq_d = SEQ_DONE;
			end
			SEQ_DONE: begin
				if (out_free) seq_d = SEQ_IDLE;
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall  = 1'b1;
		run_step    = 1'b0;
		load_result = 1'b0;
		unique case (seq_q)
			SEQ_IDLE: item_stall  = 1'b0;
			SEQ_RUN:  run_step    = 1'b1;
			SEQ_DONE: load_result = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= 4'd0;
			guard_q       <= GUARD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE_MASK: enable_mask_q <= cfg_data[3:0];
				REG_GUARD_TICKS: guard_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (item_take) begin
			tick_q     <= (mode == MODE_TICK);
			chan_ok_q  <= chan_ok;
			chan_idx_q <= chan_ext[IDX_W-1:0];
			byte_q     <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cstate_q <= DET_IDLE;
		end else if (item_take) begin
			idx_q    <= (mode == MODE_TICK) ? '0 : chan_ext[IDX_W-1:0];
			cstate_q <= DET_IDLE;
		end else if (run_step) begin
			idx_q <= idx_q + 1'b1;
			// catch the addressed channel as it leaves the unit
			if (chan_ok_q && idx_q == chan_idx_q) cstate_q <= nxt.st;
		end
	end

	assign cur = rec_q[idx_q];

	gted_chan_unit #(
		.PATTERN_LENGTH(PATTERN_LENGTH)
	) u_unit (
		.tick       (tick_q),
		.enabled    (en_vec[idx_q]),
		.data_byte  (byte_q),
		.guard_ticks(guard_q),
		.cur        (cur),
		.nxt        (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rec_q[i] <= '{st: DET_IDLE, cnt: 8'd0, mi: 5'd0};
			end
		end else if (run_step && (tick_q || chan_ok_q)) begin
			rec_q[idx_q] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			channel_state_q <= cstate_q;
			trigger_mask_q  <= mask_d;
		end
	end

	assign result_valid  = result_valid_q;
	assign channel_state = channel_state_q;
	assign trigger_mask  = trigger_mask_q;

`ifndef NO_ASSERTIONS
	a_take_runs: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> seq_q == SEQ_RUN)
		else $error("accepted word did not start a run");

	a_byte_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_RUN && !tick_q) |=> seq_q == SEQ_DONE)
		else $error("byte took more than one update step");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_DONE && !out_free) |=> seq_q == SEQ_DONE)
		else $error("result dropped while output register busy");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> result_valid_q)
		else $error("loaded result not presented");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> channel_state_q <= 3'(DET_TRIGGERED))
		else $error("reported channel state out of range");
`endif

endmodule

`default_nettype wire

[design/gted_chan_unit.sv]
// Shared channel update unit: next context of one channel for a byte or a guard tick.
// Depends on gted_pkg.
`default_nettype none

module gted_chan_unit import gted_pkg::*; #(
	parameter int PATTERN_LENGTH = 20
) (
	input  logic       tick,
	input  logic       enabled,
	input  logic [7:0] data_byte,
	input  logic [7:0] guard_ticks,
	input  chan_rec_t  cur,
	output chan_rec_t  nxt
);

	logic [4:0] ptr;
	logic [5:0] next_pos;
	logic       hit;

	always_comb begin
		nxt = cur;
		// armed always compares against the first character
		ptr = (cur.st == DET_ARMED) ? 5'd0 : cur.mi;
		next_pos = {1'b0, ptr} + 6'd1;
		hit = (data_byte == pattern_char(ptr));
		if (enabled) begin
			if (tick) begin
				if (cur.cnt >= guard_ticks) begin
					if (cur.st == DET_IDLE) begin
						nxt.st = DET_ARMED;
					end else if (cur.st == DET_MATCHED) begin
						nxt.st = DET_TRIGGERED;
					end
				end else begin
					nxt.cnt = cur.cnt + 8'd1;
				end
			end else begin
				nxt.cnt = 8'd0;
				if ((cur.st == DET_ARMED || cur.st == DET_MATCHING) && hit) begin
					if (next_pos >= 6'(PATTERN_LENGTH)) begin
						nxt.mi = 5'd0;
						nxt.st = DET_MATCHED;
					end else begin
						nxt.mi = next_pos[4:0];
						nxt.st = DET_MATCHING;
					end
				end else begin
					// drop back on any byte that breaks the string or comes when neither armed nor matching
					nxt.mi = 5'd0;
					nxt.st = DET_IDLE;
				end
			end
		end
	end

endmodule

`default_nettype wire
